// ===== rtl/mmps_pkg.sv =====
// Package for the matrix maximum path sum block.
// Holds sizes, data types and register addresses; no dependencies.
package mmps_pkg;

	// Largest matrix side the line buffer holds
	localparam int MAX_SIZE = 64;
	localparam int IDX_W    = $clog2(MAX_SIZE);

	// Field and register widths
	localparam int CELL_W  = 16;
	localparam int SUM_W   = 22;
	localparam int SIZE_W  = 7;
	localparam int APB_DW  = 32;
	localparam int APB_AW  = 2;

	// Byte address of the matrix size register
	localparam logic [APB_AW-1:0] ADDR_MATRIX_SIZE = '0;

	// Lowest value a sum can take, start of the last-row maximum
	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	typedef logic signed [CELL_W-1:0] cell_t;
	typedef logic signed [SUM_W-1:0]  sum_t;
	typedef logic [IDX_W-1:0]         idx_t;
	typedef logic [IDX_W:0]           side_t;
	typedef logic [SIZE_W-1:0]        size_t;

	// Clamp a written size to the range the block supports
	function automatic side_t size_in_use(input size_t raw);
		side_t s;
		if (raw == '0) begin
			s = side_t'(1);
		end else if (32'(raw) > MAX_SIZE) begin
			s = side_t'(MAX_SIZE);
		end else begin
			s = side_t'(raw);
		end
		return s;
	endfunction

endpackage

// ===== rtl/mmps_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; no package dependency.
module mmps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write on request, read every cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/matrix_max_path_sum_top.sv =====
// Matrix maximum path sum, top level.
// Depends on mmps_pkg and the line buffer RAM mmps_ram.
//
// Takes one signed matrix cell per clock in row-major order and, on the last
// cell of each square matrix, delivers the largest sum of a path that steps
// one row down at a time to the same or a neighboring column and ends in the
// last row. The throughput is one cell per clock while cell_stall is low;
// the result is registered in the output register, or in the skid entry
// when that register is still full. The per-cell path is the line buffer
// RAM read register, a three-way maximum and one 22-bit add and compare.
// The line buffer is read one column ahead, and the first two columns of
// each row are kept in flops so that a new row starts without a second read
// port. A two-entry output stage (result register plus skid) lets cells keep
// flowing while a result waits; cell_stall rises only when both are full.
// Writing matrix_size (byte address 0, values 0 and above 64 are clamped to
// 1 and 64) drops the matrix in progress; write it only while idle.
module matrix_max_path_sum_top (
	input  logic                         clk,
	input  logic                         arst_n,
	// Cell input channel
	input  logic                         cell_valid,
	output logic                         cell_stall,
	input  mmps_pkg::cell_t              cell_value,
	// Result channel
	output logic                         sum_valid,
	input  logic                         sum_stall,
	output mmps_pkg::sum_t               best_sum,
	// Configuration port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [mmps_pkg::APB_AW-1:0]  paddr,
	input  logic [mmps_pkg::APB_DW-1:0]  pwdata,
	output logic [mmps_pkg::APB_DW-1:0]  prdata,
	output logic                         pready
);

	import mmps_pkg::*;

	// Configuration and position state
	size_t size_q;
	idx_t  col_q;
	idx_t  row_q;
	sum_t  row_max_q;

	// Line buffer window and saved first columns
	sum_t  left_q;
	sum_t  up_q;
	sum_t  first0_q;
	sum_t  first1_q;
	idx_t  rd_addr_q;
	sum_t  ram_rdata;

	// Output stage
	logic  out_valid_q;
	sum_t  out_sum_q;
	logic  skid_valid_q;
	sum_t  skid_sum_q;

	// Per-cell datapath
	logic  cfg_wr;
	logic  accept;
	side_t side;
	logic  last_col;
	logic  last_row;
	sum_t  up_val;
	sum_t  right_val;
	sum_t  above;
	sum_t  best;
	sum_t  row_max_nxt;
	logic  emit;
	idx_t  rd_addr;
	logic  out_take;

	assign pready     = 1'b1;
	assign cfg_wr     = psel && penable && pwrite && pready && (paddr == ADDR_MATRIX_SIZE);
	assign prdata     = (paddr == ADDR_MATRIX_SIZE) ? APB_DW'(size_q) : '0;

	assign cell_stall = skid_valid_q;
	assign accept     = cell_valid && !cell_stall;
	assign sum_valid  = out_valid_q;
	assign best_sum   = out_sum_q;
	assign out_take   = out_valid_q && !sum_stall;

	assign side       = size_in_use(size_q);
	assign last_col   = ({1'b0, col_q} == side - side_t'(1));
	assign last_row   = ({1'b0, row_q} == side - side_t'(1));

	// Pick the neighbors from the row above and form the best sum
	always_comb begin
		sum_t m;
		if (col_q == '0) begin
			up_val    = first0_q;
			right_val = first1_q;
		end else begin
			up_val    = up_q;
			right_val = ram_rdata;
		end
		m = up_val;
		if (col_q != '0 && left_q > m) begin
			m = left_q;
		end
		if (!last_col && right_val > m) begin
			m = right_val;
		end
		if (m < 0 || row_q == '0) begin
			m = '0;
		end
		above = m;
		best  = sum_t'(cell_value) + above;
	end

	assign row_max_nxt = (last_row && best > row_max_q) ? best : row_max_q;
	assign emit        = accept && last_col && last_row;

	// Read one column ahead of the next cell; hold while idle
	assign rd_addr = accept ? col_q + idx_t'(2) : rd_addr_q;

	mmps_ram #(
		.WIDTH (SUM_W),
		.DEPTH (MAX_SIZE)
	) u_line_buf (
		.clk   (clk),
		.we    (accept),
		.waddr (col_q),
		.wdata (best),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	// Advance position and running maximum; restart on a size write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q    <= size_t'(MAX_SIZE);
			col_q     <= '0;
			row_q     <= '0;
			row_max_q <= SUM_MIN;
		end else if (cfg_wr) begin
			size_q    <= pwdata[SIZE_W-1:0];
			col_q     <= '0;
			row_q     <= '0;
			row_max_q <= SUM_MIN;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				if (last_row) begin
					row_q     <= '0;
					row_max_q <= SUM_MIN;
				end else begin
					row_q     <= row_q + idx_t'(1);
					row_max_q <= row_max_nxt;
				end
			end else begin
				col_q     <= col_q + idx_t'(1);
				row_max_q <= row_max_nxt;
			end
		end
	end

	// Slide the neighbor window and keep the first two columns of the row
	always_ff @(posedge clk) begin
		rd_addr_q <= rd_addr;
		if (accept) begin
			left_q <= up_val;
			up_q   <= right_val;
			if (col_q == idx_t'(0)) begin
				first0_q <= best;
			end
			if (col_q == idx_t'(1)) begin
				first1_q <= best;
			end
		end
	end

	// Output register with skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				if (out_take) begin
					out_valid_q  <= 1'b1;
					skid_valid_q <= 1'b0;
				end
			end else if (emit) begin
				if (!out_valid_q || out_take) begin
					out_valid_q <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload; no reset needed
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_take) begin
				out_sum_q <= skid_sum_q;
			end
		end else if (emit) begin
			if (!out_valid_q || out_take) begin
				out_sum_q <= row_max_nxt;
			end else begin
				skid_sum_q <= row_max_nxt;
			end
		end
	end

endmodule

// ===== rtl/mmps_chk.sv =====
// Port-level checker for the matrix maximum path sum block, and its bind.
// Depends on mmps_pkg and the top level matrix_max_path_sum_top.
module mmps_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        cell_stall,
	input logic                        sum_valid,
	input logic                        sum_stall,
	input logic [mmps_pkg::SUM_W-1:0]  best_sum,
	input logic                        pready
);

	import mmps_pkg::*;

	// Hold a stalled result
	a_sum_hold: assert property (@(posedge clk) disable iff (!arst_n)
		sum_valid && sum_stall |=> sum_valid && $stable(best_sum))
		else $error("stalled result dropped or changed");

	// Stall cells only while a result is waiting
	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		cell_stall |-> sum_valid)
		else $error("cell stall without a pending result");

	// Raise cell stall only after a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(cell_stall) |-> $past(sum_valid && sum_stall))
		else $error("cell stall rose without a stalled result");

	// Drop cell stall once the result is taken
	a_stall_release: assert property (@(posedge clk) disable iff (!arst_n)
		cell_stall && !sum_stall |=> !cell_stall)
		else $error("cell stall held after the result moved");

	// Keep the configuration port always ready
	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("configuration port not ready");

endmodule

bind matrix_max_path_sum_top mmps_chk u_mmps_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.cell_stall (cell_stall),
	.sum_valid  (sum_valid),
	.sum_stall  (sum_stall),
	.best_sum   (best_sum),
	.pready     (pready)
);
